@@ rtl/core/plel_pkg.sv @@
// Shared types and codes for the positional list engine.
// Depends on nothing; every other file of the block imports it.
package plel_pkg;

   // Operation codes of the action field.
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Field widths that the request and response beats fix.
   localparam int unsigned POS_W   = 5;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned CNT_W   = 5;

   typedef struct packed {
      logic                        action;
      logic [POS_W-1:0]            list_position;
      logic signed [VALUE_W-1:0]   new_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]   removed_value;
      logic [STAT_W-1:0]           status;
      logic [CNT_W-1:0]            entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_SHIFT,
      S_DRAIN,
      S_DONE
   } state_type;

endpackage

@@ rtl/core/plel_store.sv @@
// Entry store of the positional list engine: one write port, one read port,
// read data registered. Depends on plel_pkg.
module plel_store #(
   parameter int unsigned CAPACITY = 16,
   parameter int unsigned AW       = 4
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [plel_pkg::VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]                rd_addr,
   output logic [plel_pkg::VALUE_W-1:0] rd_data
);
   import plel_pkg::*;

   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/plel_ctrl.sv @@
// Sequencer of the positional list engine: range checks, entry count,
// the shift walk over the store and the response register. Depends on plel_pkg.
module plel_ctrl #(
   parameter int unsigned CAPACITY = 16,
   parameter int unsigned AW       = 4,
   parameter int unsigned CW       = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  plel_pkg::req_type            req_data,
   output logic                         rsp_strobe,
   output plel_pkg::rsp_type            rsp_data,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output logic [plel_pkg::VALUE_W-1:0] wr_data,
   output logic [AW-1:0]                rd_addr,
   input  logic [plel_pkg::VALUE_W-1:0] rd_data
);
   import plel_pkg::*;

   // Compare width: holds a position, a count and a count plus one.
   localparam int unsigned CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               op_ff, op_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [AW-1:0]      k_ff, k_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      end_ff, end_in;
   logic               up_ff, up_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               cap_ff, cap_in;
   logic [VALUE_W-1:0] removed_ff, removed_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CMP_W-1:0]   pos_w;
   logic [CMP_W-1:0]   cnt_w;
   logic [CMP_W-1:0]   k_w;
   logic [CMP_W-1:0]   next_cnt_w;
   logic [CW-1:0]      last_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         cap_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         cap_ff        <= cap_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      status_ff    <= status_in;
      k_ff         <= k_in;
      ptr_ff       <= ptr_in;
      end_ff       <= end_in;
      up_ff        <= up_in;
      pend_addr_ff <= pend_addr_in;
      value_ff     <= value_in;
      removed_ff   <= removed_in;
      rsp_ff       <= rsp_in;
   end

   assign pos_w  = CMP_W'(req_data.list_position);
   assign cnt_w  = CMP_W'(count_ff);
   assign k_w    = pos_w - CMP_W'(1);
   assign last_w = count_ff - CW'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      k_in          = k_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      up_in         = up_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      value_in      = value_ff;
      cap_in        = 1'b0;
      removed_in    = cap_ff ? rd_data : removed_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      next_cnt_w    = cnt_w;
      wr_en         = 1'b0;
      wr_addr       = pend_addr_ff;
      wr_data       = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_data.action;
               value_in = req_data.new_value;
               k_in     = k_w[AW-1:0];
               pend_in  = 1'b0;
               state_in = S_DONE;
               if (req_data.action == ACT_INSERT) begin
                  if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
                     status_in = ST_RANGE;
                  end else if (cnt_w >= CMP_W'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in = ST_DONE;
                     if (k_w != cnt_w) begin
                        // Walk from the tail down to the slot, moving each back.
                        ptr_in   = last_w[AW-1:0];
                        end_in   = k_w[AW-1:0];
                        up_in    = 1'b1;
                        state_in = S_SHIFT;
                     end
                  end
               end else begin
                  if (pos_w == '0 || pos_w > cnt_w) begin
                     status_in = ST_RANGE;
                  end else begin
                     status_in = ST_DONE;
                     ptr_in    = k_w[AW-1:0];
                     state_in  = S_HEAD;
                  end
               end
            end
         end
         S_HEAD: begin
            // Read the doomed entry; capture it next cycle.
            cap_in = 1'b1;
            if (ptr_ff == last_w[AW-1:0]) begin
               state_in = S_DONE;
            end else begin
               ptr_in   = ptr_ff + AW'(1);
               end_in   = last_w[AW-1:0];
               up_in    = 1'b0;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // Write back the entry read last cycle, if one is pending, and read the next one.
            wr_en        = pend_ff;
            pend_in      = 1'b1;
            pend_addr_in = up_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
            if (ptr_ff == end_ff) begin
               state_in = S_DRAIN;
            end else begin
               ptr_in = up_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            wr_en    = pend_ff;
            pend_in  = 1'b0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (op_ff == ACT_INSERT && status_ff == ST_DONE) begin
               wr_en   = 1'b1;
               wr_addr = k_ff;
               wr_data = value_ff;
            end
            if (status_ff == ST_DONE) begin
               count_in   = (op_ff == ACT_INSERT) ? count_ff + CW'(1) : last_w;
               next_cnt_w = CMP_W'(count_in);
            end
            rsp_in.status      = status_ff;
            rsp_in.entry_count = next_cnt_w[CNT_W-1:0];
            rsp_in.removed_value =
               (op_ff == ACT_DELETE && status_ff == ST_DONE) ? removed_in : '0;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rd_addr    = ptr_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(CAPACITY) >= count_ff)
      else $error("entry count above capacity");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_strobe_ff)
      else $error("finished item gave no response");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_HEAD) |-> !wr_en)
      else $error("store written outside a shift or commit");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status == ST_FULL) |-> count_ff == CW'(CAPACITY))
      else $error("full status with room left");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DONE) |=> $stable(count_ff))
      else $error("count moved outside commit");

endmodule

@@ rtl/core/positional_list_engine_unit.sv @@
// Top level of the positional list engine: ordered list with insert and
// delete at a 1-based position. Depends on plel_pkg, plel_store, plel_ctrl.
//
// A beat is taken when start is high and busy is low. An insert at position
// p of a list of n entries moves n-p+1 entries one place back. A delete
// moves n-p entries one place forward. The walk moves one entry per cycle
// through the store, which has one read port and one write port. After the
// accepting cycle, an item passes through these states:
//   - insert: S_SHIFT for the walk, S_DRAIN, then S_DONE, or S_DONE
//     alone for an insert at the end.
//   - delete: S_HEAD, which first reads the removed entry, then S_SHIFT,
//     S_DRAIN and S_DONE, or S_HEAD and S_DONE for the last entry.
//   - an item that fails its checks: S_DONE alone.
// The response beat shows on rsp_data with rsp_strobe for exactly one
// cycle, the first cycle in which busy is low again. It cannot be held
// off: take it then. Each read in the walk touches an entry other than
// the one written in the same cycle, so no forwarding path is needed.
// Stored values need no clearing pass: only entries below the count are
// ever used.
module positional_list_engine_unit #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  plel_pkg::req_type req_data,
   output logic              rsp_strobe,
   output plel_pkg::rsp_type rsp_data
);
   import plel_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;

   // Sequencer: checks, count and the shift walk.
   plel_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // Entry store, read data registered.
   plel_store #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
